// File: hdl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// Masked multi-pattern byte matcher package
// Shared item types, operation codes, status codes and state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbm_pkg;

  // Operation codes of an input item. Code 3 is unused and is dropped.
  typedef enum logic [1:0] {
    OP_WRITE_TOKEN = 2'd0,
    OP_SET_LENGTH  = 2'd1,
    OP_SCAN        = 2'd2
  } op_e;

  // Result status codes.
  localparam logic STATUS_HIT  = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  // ASCII case folding.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  // One input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  pattern_index;
    logic [4:0]  token_position;
    logic [7:0]  token_low;
    logic [7:0]  token_span;
    logic [7:0]  token_mask;
    logic [5:0]  pattern_length;
    logic [7:0]  data_byte;
    logic [63:0] byte_position;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        status;
    logic [2:0]  hit_pattern;
    logic [63:0] match_start;
    logic        last;
  } res_t;

  // One stored token entry.
  typedef struct packed {
    logic [7:0] low;
    logic [7:0] span;
    logic [7:0] mask;
  } token_t;

endpackage

`default_nettype wire

// File: hdl/mpbm_if.sv
// ----------------------------------------------------------------------------
// Masked multi-pattern byte matcher channel interfaces
// Valid/ready channels for input items, result items and the config register.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel.
interface mpbm_req_if;
  import mpbm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result item channel.
interface mpbm_res_if;
  import mpbm_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel carrying the ignore_case register.
interface mpbm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/mpbm_token_bank.sv
// ----------------------------------------------------------------------------
// Token bank of one pattern
// Synchronous token memory with a registered read and the token compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbm_token_bank #(
  parameter int unsigned MAX_TOKENS = 32,
  localparam int unsigned AW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  mpbm_pkg::token_t wr_token_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic [7:0]       byte_i,
  output logic             match_o
);
  import mpbm_pkg::*;

  token_t     mem [MAX_TOKENS];
  token_t     rd_q;
  logic [7:0] hi;

  // Token memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_token_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // A nonzero span selects an inclusive range whose upper bound wraps in
  // 8 bits; a wrapped bound below low matches nothing. Otherwise compare
  // the masked literal.
  always_comb begin
    hi = rd_q.low + rd_q.span;
    if (rd_q.span != 8'd0) begin
      match_o = (byte_i >= rd_q.low) && (byte_i <= hi);
    end else begin
      match_o = ((byte_i & rd_q.mask) == (rd_q.low & rd_q.mask));
    end
  end

endmodule

`default_nettype wire

// File: hdl/masked_multi_pattern_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// Masked multi-pattern byte matcher core
// Scans bytes against up to NUM_PATTERNS token patterns, one banked token
// memory per pattern, and reports every completed pattern with its start.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Moves                        Accepted when
//   cfg_i    in   ignore_case write            cfg_i.valid && cfg_i.ready
//   req_i    in   write, set length, scan item req_i.valid && req_i.ready
//   res_o    out  hit or no-pattern result     res_o.valid && res_o.ready
//
// A write item is accepted in the idle state. A scan item is accepted in
// the idle state, which starts the token read; the evaluate state then
// compares and updates progress, and the emit state loads result items one
// at a time, or a single no-pattern result when no pattern is enabled. The
// next item is taken once the last result has been loaded into the result
// register. A stalled result holds the sequencer in the emit state. Reset
// clears lengths, progress and ignore_case; token memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_multi_pattern_byte_matcher_core #(
  parameter int unsigned NUM_PATTERNS = 8,
  parameter int unsigned MAX_TOKENS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpbm_cfg_if.sink    cfg_i,
  mpbm_req_if.sink    req_i,
  mpbm_res_if.source  res_o
);
  import mpbm_pkg::*;

  localparam int unsigned AW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned LW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned IW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  state_e                  state_q, state_d;
  logic                    ignore_case_q;
  logic [7:0]              byte_q;
  logic [63:0]             pos_q;
  logic                    none_q;
  logic [LW-1:0]           len_q  [NUM_PATTERNS];
  logic [LW-1:0]           prog_q [NUM_PATTERNS];
  logic [LW-1:0]           prog_d [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] hits_q, hits_d, hit_new, hits_clr;
  logic [NUM_PATTERNS-1:0] match, len_nz;
  logic                    res_valid_q, res_valid_d, res_load;
  res_t                    res_q, res_d;

  logic                    req_rdy, req_acc;
  op_e                     op;
  logic                    tok_wr, len_wr, scan;
  logic [7:0]              scan_byte;
  logic [31:0]             len_ext, len_sat;
  logic [IW-1:0]           sel;
  token_t                  wr_token;

  // Decode of the accepted item.
  assign req_i.ready = req_rdy;
  assign req_acc     = req_i.valid && req_rdy;
  assign op          = op_e'(req_i.data.operation);
  assign tok_wr      = req_acc && (op == OP_WRITE_TOKEN)
                       && (32'(req_i.data.pattern_index) < NUM_PATTERNS)
                       && (32'(req_i.data.token_position) < MAX_TOKENS);
  assign len_wr      = req_acc && (op == OP_SET_LENGTH)
                       && (32'(req_i.data.pattern_index) < NUM_PATTERNS);
  assign scan        = req_acc && (op == OP_SCAN);

  // Pattern length saturates at the token capacity.
  assign len_ext = 32'(req_i.data.pattern_length);
  assign len_sat = (len_ext > MAX_TOKENS) ? MAX_TOKENS : len_ext;

  assign wr_token = '{low:  req_i.data.token_low,
                      span: req_i.data.token_span,
                      mask: req_i.data.token_mask};

  // Optional ASCII lower-casing of the scanned byte.
  always_comb begin
    scan_byte = req_i.data.data_byte;
    if (ignore_case_q && (scan_byte >= CHAR_UPPER_A) && (scan_byte <= CHAR_UPPER_Z)) begin
      scan_byte = scan_byte + CASE_OFFSET;
    end
  end

  // One token bank per pattern, read at that pattern's current progress.
  for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_bank
    assign len_nz[g] = (len_q[g] != '0);

    mpbm_token_bank #(
      .MAX_TOKENS (MAX_TOKENS)
    ) u_bank (
      .clk_i      (clk_i),
      .wr_en_i    (tok_wr && (32'(req_i.data.pattern_index) == 32'(g))),
      .wr_addr_i  (AW'(req_i.data.token_position)),
      .wr_token_i (wr_token),
      .rd_en_i    (scan),
      .rd_addr_i  (prog_q[g][AW-1:0]),
      .byte_i     (byte_q),
      .match_o    (match[g])
    );
  end

  // Progress update: advance on a match, drop to zero otherwise, and
  // restart with a hit when the pattern completes.
  always_comb begin
    logic [LW-1:0] inc_v;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      inc_v      = prog_q[p] + LW'(1);
      prog_d[p]  = prog_q[p];
      hit_new[p] = 1'b0;
      if (len_nz[p]) begin
        if (match[p]) begin
          if (inc_v == len_q[p]) begin
            hit_new[p] = 1'b1;
            prog_d[p]  = '0;
          end else begin
            prog_d[p] = inc_v;
          end
        end else begin
          prog_d[p] = '0;
        end
      end
    end
  end

  // Lowest pending hit goes out first.
  always_comb begin
    sel = '0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (hits_q[i]) begin
        sel = IW'(i);
      end
    end
    hits_clr      = hits_q;
    hits_clr[sel] = 1'b0;
  end

  // Sequencer: next state, item acceptance and result loading.
  always_comb begin
    state_d  = state_q;
    req_rdy  = 1'b0;
    res_load = 1'b0;
    hits_d   = hits_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        req_rdy = 1'b1;
        if (scan) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        hits_d = hit_new;
        if (none_q || (hit_new != '0)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          if (none_q) begin
            res_d   = '{status: STATUS_NONE, hit_pattern: 3'd0,
                        match_start: 64'd0, last: 1'b1};
            state_d = ST_IDLE;
          end else begin
            res_d.status      = STATUS_HIT;
            res_d.hit_pattern = 3'(sel);
            res_d.match_start = pos_q - 64'(len_q[sel]) + 64'd1;
            res_d.last        = (hits_clr == '0);
            hits_d            = hits_clr;
            if (hits_clr == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register handshake.
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;
  assign cfg_i.ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ignore_case_q <= 1'b0;
      res_valid_q   <= 1'b0;
      hits_q        <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      hits_q      <= hits_d;
      if (cfg_i.valid) begin
        ignore_case_q <= cfg_i.data;
      end
    end
  end

  // Per-pattern length and progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        len_q[p]  <= '0;
        prog_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (len_wr && (32'(req_i.data.pattern_index) == 32'(p))) begin
          len_q[p]  <= LW'(len_sat);
          prog_q[p] <= '0;
        end else if (state_q == ST_EVAL) begin
          prog_q[p] <= prog_d[p];
        end
      end
    end
  end

  // Scan item payload and result payload.
  always_ff @(posedge clk_i) begin
    if (scan) begin
      byte_q <= scan_byte;
      pos_q  <= req_i.data.byte_position;
      none_q <= (len_nz == '0);
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire
